// ===== sv/mcl_pkg.sv =====
// Shared types, codes and constants of the memory commitment ledger.
package mcl_pkg;

  localparam int UNIT_COUNT_DEF = 64;
  localparam int BYTE_BITS_DEF  = 48;

  localparam int ACTION_W   = 2;
  localparam int UNIT_W     = 6;
  localparam int FIELD_W    = 48;
  localparam int GRACE_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic               ENABLED_RST = 1'b1;
  localparam logic [GRACE_W-1:0] GRACE_RST   = 4'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAISE  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED = 4'd0,
    REG_GRACE   = 4'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_DIFF,
    ST_EAT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic upd;
    logic diff;
    logic eat;
    logic done;
    logic out_load;
    logic clr;
  } ctl_t;

  // anchor, high, low, promise, outstanding, flag, grace
  function automatic int entry_w(int byte_bits);
    return 5 * byte_bits + 1 + GRACE_W;
  endfunction

endpackage

// ===== sv/mcl_ifs.sv =====
// Valid/ready channel interfaces: item input, result output, register writes.
interface mcl_in_if;
  import mcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [UNIT_W-1:0]   unit_index;
  logic [FIELD_W-1:0]  raised_bytes;
  logic [FIELD_W-1:0]  use_bytes;
  modport source (output valid, action, unit_index, raised_bytes, use_bytes, input ready);
  modport sink (input valid, action, unit_index, raised_bytes, use_bytes, output ready);
endinterface

interface mcl_out_if;
  import mcl_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] outstanding_bytes;
  logic               window_live;
  modport source (output valid, outstanding_bytes, window_live, input ready);
  modport sink (input valid, outstanding_bytes, window_live, output ready);
endinterface

interface mcl_cfg_if;
  import mcl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mcl_mem.sv =====
// Single-port-write, registered-read ledger entry memory.
module mcl_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/mcl_ctrl.sv =====
// Sequencer: clearing sweep after reset, then one item at a time through the stages.
module mcl_ctrl #(
  parameter int UNIT_COUNT = mcl_pkg::UNIT_COUNT_DEF,
  parameter int AW         = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  output mcl_pkg::ctl_t ctl_o,
  output logic [AW-1:0] clr_addr_o
);
  import mcl_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(UNIT_COUNT - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_UPD;
      ST_UPD:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_EAT;
      ST_EAT:   state_d = ST_DONE;
      ST_DONE:  if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (state_q == ST_CLEAR) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
    end
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.in_ready = (state_q == ST_IDLE);
    ctl_o.rd_en    = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.upd      = (state_q == ST_UPD);
    ctl_o.diff     = (state_q == ST_DIFF);
    ctl_o.eat      = (state_q == ST_EAT);
    ctl_o.done     = (state_q == ST_DONE);
    ctl_o.out_load = (state_q == ST_DONE) && out_free_i;
    ctl_o.clr      = (state_q == ST_CLEAR);
  end

  assign clr_addr_o = clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

// ===== sv/mcl_calc.sv =====
// Entry update and outstanding recompute, one wide step per stage.
module mcl_calc #(
  parameter int UNIT_COUNT = mcl_pkg::UNIT_COUNT_DEF,
  parameter int BYTE_BITS  = mcl_pkg::BYTE_BITS_DEF,
  parameter int AW         = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1,
  parameter int ENTRY_W    = mcl_pkg::entry_w(BYTE_BITS)
) (
  input  logic                           clk_i,
  input  mcl_pkg::ctl_t                  ctl_i,
  input  logic [mcl_pkg::ACTION_W-1:0]   action_i,
  input  logic [mcl_pkg::UNIT_W-1:0]     unit_index_i,
  input  logic [mcl_pkg::FIELD_W-1:0]    raised_bytes_i,
  input  logic [mcl_pkg::FIELD_W-1:0]    use_bytes_i,
  input  logic                           en_i,
  input  logic [mcl_pkg::GRACE_W-1:0]    grace_reload_i,
  input  logic [ENTRY_W-1:0]             rd_data_i,
  output logic [ENTRY_W-1:0]             wr_data_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic                           wr_req_o,
  output logic [mcl_pkg::FIELD_W-1:0]    outstanding_bytes_o,
  output logic                           window_live_o
);
  import mcl_pkg::*;

  localparam int BB      = BYTE_BITS;
  localparam int OFS_OST = GRACE_W + 1;
  localparam int OFS_PRM = OFS_OST + BB;
  localparam int OFS_LO  = OFS_PRM + BB;
  localparam int OFS_HI  = OFS_LO + BB;
  localparam int OFS_ANC = OFS_HI + BB;

  // captured item
  logic [ACTION_W-1:0] act_q;
  logic                unit_ok_q;
  logic [AW-1:0]       addr_q;
  logic [BB-1:0]       raised_q, use_q;

  // updated entry fields
  logic [BB-1:0]      anc_q, hi_q, lo_q, prm_q;
  logic [GRACE_W-1:0] grc_q;
  logic               wr_q;
  logic [BB-1:0]      anc_d, hi_d, lo_d, prm_d;
  logic [GRACE_W-1:0] grc_d;
  logic               wr_d;

  logic [BB-1:0]      growth_q, drop_q, eat_q;

  // stored entry
  logic [GRACE_W-1:0] grc_old;
  logic               flag_old;
  logic [BB-1:0]      ost_old, prm_old, lo_old, hi_old, anc_old;
  logic               live_old;
  logic [BB:0]        prm_sum;

  logic [BB:0]        g_sub, d_sub, o_sub;
  logic [BB-1:0]      ost_new;
  logic               flag_new;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      act_q     <= action_i;
      unit_ok_q <= int'(unit_index_i) < UNIT_COUNT;
      addr_q    <= AW'(unit_index_i);
      raised_q  <= BB'(raised_bytes_i);
      use_q     <= BB'(use_bytes_i);
    end
  end

  assign grc_old  = rd_data_i[GRACE_W-1:0];
  assign flag_old = rd_data_i[GRACE_W];
  assign ost_old  = rd_data_i[OFS_OST +: BB];
  assign prm_old  = rd_data_i[OFS_PRM +: BB];
  assign lo_old   = rd_data_i[OFS_LO +: BB];
  assign hi_old   = rd_data_i[OFS_HI +: BB];
  assign anc_old  = rd_data_i[OFS_ANC +: BB];
  assign live_old = flag_old && (ost_old != '0);
  assign prm_sum  = {1'b0, prm_old} + {1'b0, raised_q};

  always_comb begin
    anc_d = anc_old;
    hi_d  = hi_old;
    lo_d  = lo_old;
    prm_d = prm_old;
    grc_d = grc_old;
    wr_d  = 1'b0;
    priority if (unit_ok_q && act_q == ACT_RAISE && raised_q != '0 && en_i) begin
      wr_d = 1'b1;
      if (!live_old) begin
        anc_d = use_q;
        hi_d  = use_q;
        lo_d  = use_q;
      end else if (use_q > hi_old) begin
        hi_d = use_q;
      end
      grc_d = grace_reload_i;
      prm_d = prm_sum[BB] ? '1 : prm_sum[BB-1:0];
    end else if (unit_ok_q && act_q == ACT_SAMPLE && live_old) begin
      wr_d = 1'b1;
      if (use_q > hi_old) begin
        hi_d = use_q;
      end
      if (grc_old != '0) begin
        grc_d = grc_old - GRACE_W'(1);
      end else if (use_q < lo_old) begin
        lo_d = use_q;
      end
    end else begin
      wr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      anc_q <= anc_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      prm_q <= prm_d;
      grc_q <= grc_d;
      wr_q  <= wr_d;
    end
  end

  assign g_sub = {1'b0, hi_q} - {1'b0, anc_q};
  assign d_sub = {1'b0, anc_q} - {1'b0, lo_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.diff) begin
      growth_q <= g_sub[BB] ? '0 : g_sub[BB-1:0];
      drop_q   <= d_sub[BB] ? '0 : d_sub[BB-1:0];
    end
    if (ctl_i.eat) begin
      eat_q <= (growth_q > drop_q) ? growth_q : drop_q;
    end
  end

  assign o_sub    = {1'b0, prm_q} - {1'b0, eat_q};
  assign ost_new  = o_sub[BB] ? '0 : o_sub[BB-1:0];
  assign flag_new = (ost_new != '0);

  assign wr_data_o = {anc_q, hi_q, lo_q, prm_q, ost_new, flag_new, grc_q};
  assign wr_addr_o = addr_q;
  assign wr_req_o  = wr_q;

  assign outstanding_bytes_o = (unit_ok_q && en_i) ? FIELD_W'(ost_new) : '0;
  assign window_live_o       = unit_ok_q && flag_new;

endmodule

// ===== sv/memory_commitment_ledger_unit.sv =====
// Top level of the memory commitment ledger.
//
//   channel  dir  beat contents
//   in_i     in   action, unit_index, raised_bytes, use_bytes
//   out_o    out  outstanding_bytes, window_live
//   cfg_i    in   index (0 ledger_enabled, 1 grace_reload), data
//
// Each item passes from acceptance to the result register through these steps: entry memory
// read at acceptance, then update, growth/drop, max, and recompute with write-back.
// One item is in flight at a time; the next can be accepted in the cycle after the
// result loads.
// After reset the entry memory is swept to zero, with in_i not ready meanwhile;
// cfg_i is always ready.
// A waiting result holds the last stage until out_o has room.
module memory_commitment_ledger_unit #(
  parameter int UNIT_COUNT = mcl_pkg::UNIT_COUNT_DEF,
  parameter int BYTE_BITS  = mcl_pkg::BYTE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcl_in_if.sink    in_i,
  mcl_out_if.source out_o,
  mcl_cfg_if.sink   cfg_i
);
  import mcl_pkg::*;

  localparam int AW      = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int ENTRY_W = entry_w(BYTE_BITS);

  ctl_t               ctl;
  logic [AW-1:0]      clr_addr;
  logic               out_free;

  logic               en_q;
  logic [GRACE_W-1:0] grace_q;

  logic [ENTRY_W-1:0] rd_data, wr_data, mem_wdata;
  logic [AW-1:0]      wr_addr, mem_waddr;
  logic               wr_req, mem_we;

  logic [FIELD_W-1:0] res_bytes;
  logic               res_live;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_bytes_q;
  logic               out_live_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= ENABLED_RST;
      grace_q <= GRACE_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_ENABLED) begin
        en_q <= cfg_i.data[0];
      end
      if (cfg_i.index == REG_GRACE) begin
        grace_q <= cfg_i.data[GRACE_W-1:0];
      end
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  mcl_ctrl #(
    .UNIT_COUNT (UNIT_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .clr_addr_o (clr_addr)
  );

  assign in_i.ready = ctl.in_ready;

  assign mem_we    = ctl.clr || (ctl.out_load && wr_req);
  assign mem_waddr = ctl.clr ? clr_addr : wr_addr;
  assign mem_wdata = ctl.clr ? '0 : wr_data;

  mcl_mem #(
    .WIDTH (ENTRY_W),
    .DEPTH (UNIT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (ctl.rd_en),
    .rd_addr_i (AW'(in_i.unit_index)),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  mcl_calc #(
    .UNIT_COUNT (UNIT_COUNT),
    .BYTE_BITS  (BYTE_BITS),
    .AW         (AW),
    .ENTRY_W    (ENTRY_W)
  ) u_calc (
    .clk_i               (clk_i),
    .ctl_i               (ctl),
    .action_i            (in_i.action),
    .unit_index_i        (in_i.unit_index),
    .raised_bytes_i      (in_i.raised_bytes),
    .use_bytes_i         (in_i.use_bytes),
    .en_i                (en_q),
    .grace_reload_i      (grace_q),
    .rd_data_i           (rd_data),
    .wr_data_o           (wr_data),
    .wr_addr_o           (wr_addr),
    .wr_req_o            (wr_req),
    .outstanding_bytes_o (res_bytes),
    .window_live_o       (res_live)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_bytes_q <= res_bytes;
      out_live_q  <= res_live;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.outstanding_bytes = out_bytes_q;
  assign out_o.window_live       = out_live_q;

  a_accept_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> ##4 ctl.done)
    else $error("item did not reach write-back four cycles after acceptance");

  a_one_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.in_ready, ctl.upd, ctl.diff, ctl.eat, ctl.done, ctl.clr}))
    else $error("sequencer in more than one phase");

  a_write_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (ctl.clr || ctl.done))
    else $error("entry memory written outside clear or write-back");

endmodule

// ===== tb/sv/tb_memory_commitment_ledger_unit.sv =====
// Self-checking testbench of the memory commitment ledger: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_memory_commitment_ledger_unit;
  import mcl_pkg::*;

  localparam int UNITS          = UNIT_COUNT_DEF;
  localparam int SEGMENTS       = 6;
  localparam int ITEMS_PER_SEG  = 215;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int NO_BEAT_LIMIT  = 4000;

  localparam logic [ACTION_W-1:0]  ACT_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;
  localparam logic [FIELD_W-1:0]   BYTE_MAX     = '1;
  localparam logic [FIELD_W-1:0]   FIVES        = 48'h5555_5555_5555;
  localparam logic [FIELD_W-1:0]   TENS         = 48'hAAAA_AAAA_AAAA;

  typedef struct packed {
    logic [FIELD_W-1:0] bytes;
    logic               live;
  } ledger_report_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [ACTION_W-1:0]   act;
    logic [UNIT_W-1:0]     unit;
    logic [FIELD_W-1:0]    raised;
    logic [FIELD_W-1:0]    used;
    bit                    typed;
    ledger_report_t        want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mcl_in_if  in_if ();
  mcl_out_if out_if ();
  mcl_cfg_if cfg_if ();

  memory_commitment_ledger_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // ledger mirror
  logic [FIELD_W-1:0] p_anchor  [UNITS];
  logic [FIELD_W-1:0] p_high    [UNITS];
  logic [FIELD_W-1:0] p_low     [UNITS];
  logic [FIELD_W-1:0] p_promise [UNITS];
  logic [FIELD_W-1:0] p_owed    [UNITS];
  logic               p_live    [UNITS];
  logic [GRACE_W-1:0] p_grace   [UNITS];
  logic               p_enabled      = ENABLED_RST;
  logic [GRACE_W-1:0] p_grace_reload = GRACE_RST;

  ledger_report_t report_q [$];
  stim_row_t      stim_rows [$];
  logic [FIELD_W-1:0] unit_base [UNITS];

  int in_beats      = 0;
  int cfg_beats     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int holdoff_asks  = 0;
  int traffic_mode  = 0;
  int send_idle_pct [3] = '{7, 57, 0};
  int recv_idle_pct [3] = '{57, 7, 0};
  logic [GRACE_W-1:0] seg_grace [SEGMENTS] = '{4'd3, 4'd0, 4'd15, 4'd7, 4'd1, 4'd15};

  bit             item_typed;
  ledger_report_t item_want;

  function automatic void refresh_owed(int u);
    logic [FIELD_W-1:0] growth, drop, eaten;
    growth = (p_high[u] > p_anchor[u]) ? p_high[u] - p_anchor[u] : '0;
    drop = (p_anchor[u] > p_low[u]) ? p_anchor[u] - p_low[u] : '0;
    eaten = (growth > drop) ? growth : drop;
    p_owed[u] = (eaten >= p_promise[u]) ? '0 : p_promise[u] - eaten;
    p_live[u] = (p_owed[u] != '0);
  endfunction

  function automatic ledger_report_t ledger_apply(logic [ACTION_W-1:0] act,
                                                  logic [UNIT_W-1:0] u,
                                                  logic [FIELD_W-1:0] raised,
                                                  logic [FIELD_W-1:0] used);
    ledger_report_t r;
    if (act == ACT_RAISE) begin
      if (raised != '0 && p_enabled) begin
        if (!p_live[u] || p_owed[u] == '0) begin
          p_anchor[u] = used;
          p_high[u] = used;
          p_low[u] = used;
          p_live[u] = 1'b1;
        end else if (used > p_high[u]) begin
          p_high[u] = used;
        end
        p_grace[u] = p_grace_reload;
        p_promise[u] = (raised > BYTE_MAX - p_promise[u]) ? BYTE_MAX : p_promise[u] + raised;
        refresh_owed(u);
      end
    end else if (act == ACT_SAMPLE) begin
      if (p_live[u] && p_owed[u] != '0) begin
        if (used > p_high[u]) p_high[u] = used;
        if (p_grace[u] != '0) p_grace[u] = p_grace[u] - 1'b1;
        else if (used < p_low[u]) p_low[u] = used;
        refresh_owed(u);
      end
    end
    r.bytes = p_enabled ? p_owed[u] : '0;
    r.live = p_live[u];
    return r;
  endfunction

  task automatic item_row(logic [ACTION_W-1:0] act, logic [UNIT_W-1:0] unit,
                          logic [FIELD_W-1:0] raised, logic [FIELD_W-1:0] used,
                          bit typed, logic [FIELD_W-1:0] bytes, logic live);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_index = '0;
    row.reg_data = '0;
    row.act = act;
    row.unit = unit;
    row.raised = raised;
    row.used = used;
    row.typed = typed;
    row.want.bytes = bytes;
    row.want.live = live;
    stim_rows.push_back(row);
  endtask

  task automatic reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind = ROW_REG;
    row.reg_index = idx;
    row.reg_data = data;
    row.act = ACT_QUERY;
    row.unit = '0;
    row.raised = '0;
    row.used = '0;
    row.typed = 1'b0;
    row.want = '0;
    stim_rows.push_back(row);
  endtask

  task automatic send_item(logic [ACTION_W-1:0] act, logic [UNIT_W-1:0] unit,
                           logic [FIELD_W-1:0] raised, logic [FIELD_W-1:0] used,
                           bit typed, ledger_report_t want);
    int seen;
    while ($urandom_range(0, 99) < send_idle_pct[traffic_mode]) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.action = act;
    in_if.unit_index = unit;
    in_if.raised_bytes = raised;
    in_if.use_bytes = used;
    item_typed = typed;
    item_want = want;
    seen = in_beats;
    do @(negedge clk); while (in_beats == seen);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int seen;
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    seen = cfg_beats;
    do @(negedge clk); while (cfg_beats == seen);
    cfg_if.valid = 1'b0;
  endtask

  // wait until every beat owed has come back and the pipe is empty
  task automatic settle();
    in_if.valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : sink_side
    int hold_left, asks_seen;
    hold_left = 0;
    asks_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_asks != asks_seen) begin
        asks_seen = holdoff_asks;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct[traffic_mode]);
      end
    end
  end

  always @(posedge clk) begin : monitor
    ledger_report_t calc, want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_beats++;
        moved = 1'b1;
        if (cfg_if.index == REG_ENABLED) p_enabled = cfg_if.data[0];
        else if (cfg_if.index == REG_GRACE) p_grace_reload = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) begin
        in_beats++;
        moved = 1'b1;
        calc = ledger_apply(in_if.action, in_if.unit_index, in_if.raised_bytes,
                            in_if.use_bytes);
        report_q.push_back(item_typed ? item_want : calc);
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, outstanding %h live %b", $time,
                   out_if.outstanding_bytes, out_if.window_live);
        end else begin
          want = report_q.pop_front();
          if (out_if.outstanding_bytes !== want.bytes) begin
            mismatches++;
            $display("%0t: outstanding_bytes expected %h, got %h", $time, want.bytes,
                     out_if.outstanding_bytes);
          end
          if (out_if.window_live !== want.live) begin
            mismatches++;
            $display("%0t: window_live expected %b, got %b", $time, want.live,
                     out_if.window_live);
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= NO_BEAT_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, NO_BEAT_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int i, seg, n, pick;
    logic [ACTION_W-1:0] act;
    logic [UNIT_W-1:0] unit;
    logic [FIELD_W-1:0] raised, used, jitter;
    ledger_report_t none_r;

    for (i = 0; i < UNITS; i++) begin
      p_anchor[i] = '0;
      p_high[i] = '0;
      p_low[i] = '0;
      p_promise[i] = '0;
      p_owed[i] = '0;
      p_live[i] = 1'b0;
      p_grace[i] = '0;
      unit_base[i] = (i % 2) ? 48'({$urandom(), $urandom()}) : 48'($urandom_range(0, 65535));
    end
    none_r = '0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_QUERY;
    in_if.unit_index = '0;
    in_if.raised_bytes = '0;
    in_if.use_bytes = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ENABLED;
    cfg_if.data = '0;
    item_typed = 1'b0;
    item_want = '0;

    item_row(ACT_QUERY,  6'd0,  '0,       '0,        1, '0,       1'b0);
    item_row(ACT_SAMPLE, 6'd1,  '0,       48'd100,   1, '0,       1'b0);
    item_row(ACT_RAISE,  6'd2,  '0,       48'd5,     1, '0,       1'b0);
    item_row(ACT_RAISE,  6'd3,  48'd1000, 48'd500,   1, 48'd1000, 1'b1);
    item_row(ACT_SAMPLE, 6'd3,  '0,       48'd700,   1, 48'd800,  1'b1);
    item_row(ACT_SAMPLE, 6'd3,  '0,       48'd100,   1, 48'd800,  1'b1);
    item_row(ACT_SAMPLE, 6'd3,  '0,       48'd100,   1, 48'd800,  1'b1);
    item_row(ACT_SAMPLE, 6'd3,  '0,       48'd100,   1, 48'd600,  1'b1);
    item_row(ACT_RAISE,  6'd3,  '0,       48'd50,    1, 48'd600,  1'b1);
    item_row(ACT_SPARE,  6'd3,  48'd123,  48'd456,   1, 48'd600,  1'b1);
    item_row(ACT_SAMPLE, 6'd3,  '0,       48'd2000,  1, '0,       1'b0);
    item_row(ACT_SAMPLE, 6'd3,  '0,       '0,        1, '0,       1'b0);
    item_row(ACT_RAISE,  6'd4,  BYTE_MAX, BYTE_MAX,  1, BYTE_MAX, 1'b1);
    item_row(ACT_RAISE,  6'd4,  BYTE_MAX, '0,        1, BYTE_MAX, 1'b1);
    item_row(ACT_SAMPLE, 6'd4,  '0,       '0,        1, BYTE_MAX, 1'b1);
    item_row(ACT_RAISE,  6'd63, FIVES,    TENS,      1, FIVES,    1'b1);
    item_row(ACT_RAISE,  6'd63, TENS,     FIVES,     1, BYTE_MAX, 1'b1);
    item_row(ACT_SAMPLE, 6'd63, '0,       BYTE_MAX,  1, TENS,     1'b1);
    reg_row(REG_ENABLED, 4'b1110);
    item_row(ACT_RAISE,  6'd5,  48'd100,  48'd1,     1, '0,       1'b0);
    item_row(ACT_QUERY,  6'd4,  '0,       '0,        1, '0,       1'b1);
    item_row(ACT_SAMPLE, 6'd4,  '0,       48'd5,     1, '0,       1'b1);
    reg_row(REG_UNMAPPED, 4'b1111);
    item_row(ACT_QUERY,  6'd63, '0,       '0,        1, '0,       1'b1);
    reg_row(REG_ENABLED, 4'b0001);
    reg_row(REG_GRACE, 4'd0);
    item_row(ACT_RAISE,  6'd6,  48'd40,   48'd1000,  1, 48'd40,   1'b1);
    item_row(ACT_SAMPLE, 6'd6,  '0,       48'd990,   1, 48'd30,   1'b1);
    reg_row(REG_GRACE, 4'd15);
    item_row(ACT_RAISE,  6'd6,  48'd10,   48'd900,   1, 48'd40,   1'b1);
    item_row(ACT_SAMPLE, 6'd6,  '0,       48'd500,   0, '0,       1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
      end else begin
        send_item(stim_rows[i].act, stim_rows[i].unit, stim_rows[i].raised,
                  stim_rows[i].used, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      traffic_mode = seg / 2;
      write_reg(REG_ENABLED, {3'($urandom_range(0, 7)), (seg != 3)});
      write_reg(REG_GRACE, seg_grace[seg]);
      write_reg(4'($urandom_range(2, 15)), 4'($urandom_range(0, 15)));
      for (n = 0; n < ITEMS_PER_SEG; n++) begin
        // long output stall while items keep coming
        if (seg == 0 && n == 20) holdoff_asks++;
        pick = $urandom_range(0, 99);
        if (pick < 35) act = ACT_RAISE;
        else if (pick < 80) act = ACT_SAMPLE;
        else if (pick < 93) act = ACT_QUERY;
        else act = ACT_SPARE;
        unit = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 7))
                                            : 6'($urandom_range(0, UNITS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 3) unit_base[unit] = 48'({$urandom(), $urandom()});
        else if (pick < 5) unit_base[unit] = $urandom_range(0, 1) ? BYTE_MAX : '0;
        jitter = 48'($urandom_range(0, 2000));
        if ($urandom_range(0, 1))
          used = (unit_base[unit] > BYTE_MAX - jitter) ? BYTE_MAX : unit_base[unit] + jitter;
        else
          used = (unit_base[unit] < jitter) ? '0 : unit_base[unit] - jitter;
        pick = $urandom_range(0, 99);
        if (pick < 5) raised = '0;
        else if (pick < 10) raised = 48'({$urandom(), $urandom()});
        else if (pick < 13) raised = BYTE_MAX;
        else raised = 48'($urandom_range(1, 2500));
        if (act == ACT_RAISE && $urandom_range(0, 99) < 30) unit_base[unit] = used;
        send_item(act, unit, raised, used, 1'b0, none_r);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
